/* hw/rtl/pcd_pkg.sv */
`default_nettype none
package pcd_pkg;

  localparam int DEF_CACHE_ENTRIES = 8;
  localparam int DEF_PAGE_BITS     = 16;

  localparam int OPCODE_W     = 2;
  localparam int PAGE_FIELD_W = 16;
  localparam int SLOT_W       = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_PROBE  = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

endpackage
`default_nettype wire

/* hw/rtl/pcd_match.sv */
`default_nettype none
// Tag compare across all entries plus a search for the lowest unused slot.
module pcd_match #(
  parameter int CACHE_ENTRIES = pcd_pkg::DEF_CACHE_ENTRIES,
  parameter int PAGE_BITS     = pcd_pkg::DEF_PAGE_BITS,
  localparam int IDX_W        = $clog2(CACHE_ENTRIES)
) (
  input  wire logic                 entry_valid [CACHE_ENTRIES],
  input  wire logic [PAGE_BITS-1:0] entry_page  [CACHE_ENTRIES],
  input  wire logic [PAGE_BITS-1:0] page,
  output logic                      hit,
  output logic [IDX_W-1:0]          hit_idx,
  output logic                      any_free,
  output logic [IDX_W-1:0]          free_idx
);

  logic [CACHE_ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_page[i] == page);
    end
  end

  // Scanning from the top down leaves the lowest matching or free index.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pcd_victim.sv */
`default_nettype none
// Balanced compare tree that finds the entry furthest from the requested page.
// The right branch only wins on a strictly larger distance, so ties go to the
// lower index.
module pcd_victim #(
  parameter int CACHE_ENTRIES = pcd_pkg::DEF_CACHE_ENTRIES,
  parameter int PAGE_BITS     = pcd_pkg::DEF_PAGE_BITS,
  localparam int IDX_W        = $clog2(CACHE_ENTRIES)
) (
  input  wire logic [PAGE_BITS-1:0] entry_page [CACHE_ENTRIES],
  input  wire logic [PAGE_BITS-1:0] page,
  output logic [IDX_W-1:0]          victim_idx,
  output logic [PAGE_BITS-1:0]      victim_page
);

  localparam int LEAVES = 1 << IDX_W;

  logic                 node_live [1:2*LEAVES-1];
  logic [PAGE_BITS-1:0] node_dist [1:2*LEAVES-1];
  logic [IDX_W-1:0]     node_idx  [1:2*LEAVES-1];
  logic [PAGE_BITS-1:0] node_page [1:2*LEAVES-1];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < CACHE_ENTRIES) begin : g_real
      assign node_live[LEAVES+i] = 1'b1;
      assign node_dist[LEAVES+i] = (entry_page[i] >= page) ? (entry_page[i] - page)
                                                           : (page - entry_page[i]);
      assign node_page[LEAVES+i] = entry_page[i];
    end else begin : g_pad
      assign node_live[LEAVES+i] = 1'b0;
      assign node_dist[LEAVES+i] = '0;
      assign node_page[LEAVES+i] = '0;
    end
    assign node_idx[LEAVES+i] = IDX_W'(i);
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic take_right;
    assign take_right = node_live[2*k+1] &&
                        (!node_live[2*k] || (node_dist[2*k+1] > node_dist[2*k]));
    assign node_live[k] = node_live[2*k] || node_live[2*k+1];
    assign node_dist[k] = take_right ? node_dist[2*k+1] : node_dist[2*k];
    assign node_idx[k]  = take_right ? node_idx[2*k+1]  : node_idx[2*k];
    assign node_page[k] = take_right ? node_page[2*k+1] : node_page[2*k];
  end

  assign victim_idx  = node_idx[1];
  assign victim_page = node_page[1];

endmodule
`default_nettype wire

/* hw/rtl/page_cache_directory.sv */
`default_nettype none
// Fully associative page directory with furthest-distance replacement. A
// request is taken into an input register, resolved by a parallel tag
// compare and a distance compare tree, and its result is held in an output
// register, loaded from the input register when it is empty or being read;
// one request is taken every cycle while the result side keeps up. The
// directory state is updated in the same cycle the result is registered, so a
// request always sees every update of the request before it. Unused opcode
// values produce an all-zero result and change nothing.
module page_cache_directory #(
  parameter int CACHE_ENTRIES = pcd_pkg::DEF_CACHE_ENTRIES,
  parameter int PAGE_BITS     = pcd_pkg::DEF_PAGE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [pcd_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire logic [pcd_pkg::PAGE_FIELD_W-1:0] in_page_number,
  input  wire logic                             in_load_ok,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_hit,
  output logic [pcd_pkg::SLOT_W-1:0]            out_slot,
  output logic                                  out_evicted_valid,
  output logic [pcd_pkg::PAGE_FIELD_W-1:0]      out_evicted_page
);

  localparam int IDX_W  = $clog2(CACHE_ENTRIES);
  localparam int SLOT_W = pcd_pkg::SLOT_W;
  localparam int PF_W   = pcd_pkg::PAGE_FIELD_W;

  // Input register
  logic                             s1_valid_r;
  logic [pcd_pkg::OPCODE_W-1:0]     s1_opcode_r;
  logic [PF_W-1:0]                  s1_page_r;
  logic                             s1_load_ok_r;

  // Directory state
  logic                 entry_valid_r   [CACHE_ENTRIES];
  logic                 entry_valid_nxt [CACHE_ENTRIES];
  logic [PAGE_BITS-1:0] entry_page_r    [CACHE_ENTRIES];
  logic [PAGE_BITS-1:0] entry_page_nxt  [CACHE_ENTRIES];

  // Result register
  logic              out_valid_r;
  logic              out_hit_r,  out_hit_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_ev_valid_r, out_ev_valid_nxt;
  logic [PF_W-1:0]   out_ev_page_r,  out_ev_page_nxt;

  logic                 s1_advance;
  logic [PAGE_BITS-1:0] page;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 any_free;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     victim_idx;
  logic [PAGE_BITS-1:0] victim_page;
  logic [IDX_W-1:0]     fill_idx;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign page       = PAGE_BITS'(s1_page_r);
  assign fill_idx   = any_free ? free_idx : victim_idx;

  pcd_match #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PAGE_BITS     (PAGE_BITS)
  ) u_match (
    .entry_valid (entry_valid_r),
    .entry_page  (entry_page_r),
    .page        (page),
    .hit         (hit),
    .hit_idx     (hit_idx),
    .any_free    (any_free),
    .free_idx    (free_idx)
  );

  pcd_victim #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .PAGE_BITS     (PAGE_BITS)
  ) u_victim (
    .entry_page  (entry_page_r),
    .page        (page),
    .victim_idx  (victim_idx),
    .victim_page (victim_page)
  );

  always_comb begin
    entry_valid_nxt  = entry_valid_r;
    entry_page_nxt   = entry_page_r;
    out_hit_nxt      = 1'b0;
    out_slot_nxt     = '0;
    out_ev_valid_nxt = 1'b0;
    out_ev_page_nxt  = '0;
    unique case (s1_opcode_r)
      pcd_pkg::OP_ACCESS: begin
        if (hit) begin
          out_hit_nxt  = 1'b1;
          out_slot_nxt = SLOT_W'(hit_idx);
        end else begin
          out_slot_nxt              = SLOT_W'(fill_idx);
          entry_page_nxt[fill_idx]  = page;
          entry_valid_nxt[fill_idx] = s1_load_ok_r;
          // With no free slot the victim is always a valid entry.
          if (!any_free) begin
            out_ev_valid_nxt = 1'b1;
            out_ev_page_nxt  = PF_W'(victim_page);
          end
        end
      end
      pcd_pkg::OP_PROBE: begin
        if (hit) begin
          out_hit_nxt  = 1'b1;
          out_slot_nxt = SLOT_W'(hit_idx);
        end
      end
      pcd_pkg::OP_FLUSH: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          entry_valid_nxt[i] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        entry_valid_r[i] <= 1'b0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        out_valid_r   <= 1'b1;
        entry_valid_r <= entry_valid_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_opcode_r  <= in_opcode;
      s1_page_r    <= in_page_number;
      s1_load_ok_r <= in_load_ok;
    end
    if (s1_advance) begin
      entry_page_r   <= entry_page_nxt;
      out_hit_r      <= out_hit_nxt;
      out_slot_r     <= out_slot_nxt;
      out_ev_valid_r <= out_ev_valid_nxt;
      out_ev_page_r  <= out_ev_page_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;

endmodule
`default_nettype wire

/* hw/rtl/pcd_checker.sv */
`default_nettype none
module pcd_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_hit,
  input wire logic [pcd_pkg::SLOT_W-1:0]       out_slot,
  input wire logic                             out_evicted_valid,
  input wire logic [pcd_pkg::PAGE_FIELD_W-1:0] out_evicted_page
);

  // A result held back by the sink must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_slot) &&
      $stable(out_evicted_valid) && $stable(out_evicted_page))
    else $error("result changed while stalled");

  // An eviction only happens on a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted_valid |-> !out_hit)
    else $error("eviction reported together with a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without an eviction");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With an empty pipeline the block must take a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid && $past(rst_n) && !$past(in_valid) |=> in_ready)
    else $error("input not ready with nothing in flight");

endmodule

bind page_cache_directory pcd_checker u_pcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit           (out_hit),
  .out_slot          (out_slot),
  .out_evicted_valid (out_evicted_valid),
  .out_evicted_page  (out_evicted_page)
);
`default_nettype wire
